>>> src/nmpls_pkg.sv
`timescale 1ns / 1ps
package nmpls_pkg;

  localparam int COORD_BITS = 12;
  localparam int LAMP_COUNT = 3;
  localparam int FALLOFF_ENTRIES = 1024;
  localparam int ROM_AW = $clog2(FALLOFF_ENTRIES);
  localparam int DIST_W = 2 * COORD_BITS + 1;
  localparam int RAD_W = 20;
  localparam int QUO_W = DIST_W;
  localparam int LAMP_LAT = QUO_W + 5;
  localparam int EMBOSS_BIAS = 74;
  localparam int CFG_W = 44;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_L0_PLACE = 3'd0,
    REG_L0_LOOK  = 3'd1,
    REG_L1_PLACE = 3'd2,
    REG_L1_LOOK  = 3'd3,
    REG_L2_PLACE = 3'd4,
    REG_L2_LOOK  = 3'd5,
    REG_AMBIENT  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic signed [8:0]     vx;
    logic signed [8:0]     vy;
    logic [RAD_W-1:0]      rad;
    logic [7:0]            r;
    logic [7:0]            g;
    logic [7:0]            b;
  } lamp_t;

endpackage

>>> src/nmpls_div.sv
`timescale 1ns / 1ps
module nmpls_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  logic [nmpls_pkg::DIST_W-1:0] num_i,
  input  logic [nmpls_pkg::QUO_W-1:0]  quo_i,
  input  logic [nmpls_pkg::RAD_W-1:0]  den_i,
  input  logic                       vld_chk_i,
  output logic                       vld_o,
  output logic [nmpls_pkg::DIST_W-1:0] num_o,
  output logic [nmpls_pkg::QUO_W-1:0]  quo_o,
  input  logic [4:0]                 bit_i
);
  import nmpls_pkg::*;
  // one restoring-division cell: decides one quotient bit
  logic [DIST_W+RAD_W-1:0] sh;
  logic take;
  always_comb begin
    sh = (DIST_W+RAD_W)'(den_i) << bit_i;
    take = (DIST_W+RAD_W)'(num_i) >= sh;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i & vld_chk_i;
    end
  end
  always_ff @(posedge clk_i) begin
    num_o <= take ? DIST_W'((DIST_W+RAD_W)'(num_i) - sh) : num_i;
    quo_o <= quo_i | (take ? (QUO_W'(1) << bit_i) : '0);
  end
endmodule

>>> src/nmpls_lamp.sv
`timescale 1ns / 1ps
module nmpls_lamp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         vld_i,
  input  nmpls_pkg::lamp_t             lamp_i,
  input  logic [nmpls_pkg::COORD_BITS-1:0] px_i,
  input  logic [nmpls_pkg::COORD_BITS-1:0] py_i,
  input  logic signed [7:0]            nx_i,
  input  logic signed [7:0]            ny_i,
  input  logic [9:0]                   r_i,
  input  logic [9:0]                   g_i,
  input  logic [9:0]                   b_i,
  output logic                         vld_o,
  output logic [9:0]                   r_o,
  output logic [9:0]                   g_o,
  output logic [9:0]                   b_o
);
  import nmpls_pkg::*;
  localparam int NDIV = QUO_W;
  localparam int NS = LAMP_LAT - 1;
  localparam int SR = NDIV + 2;

  logic [NS:0] vld_q;
  logic [9:0] r_q [NS];
  logic [9:0] g_q [NS];
  logic [9:0] b_q [NS];
  logic [7:0] d_q [1:SR];

  // falloff table
  logic [7:0] rom_w [FALLOFF_ENTRIES];
  for (genvar j = 0; j < FALLOFF_ENTRIES; j++) begin : g_rom
    localparam longint E = longint'(FALLOFF_ENTRIES - j);
    localparam longint V = (255 * E * E) /
                           (longint'(FALLOFF_ENTRIES) * longint'(FALLOFF_ENTRIES + 7 * j));
    assign rom_w[j] = 8'(V);
  end

  // stage 0: products
  logic signed [17:0] px_d;
  logic signed [17:0] py_d;
  logic signed [COORD_BITS:0] dx, dy;
  logic signed [2*COORD_BITS+1:0] dxx, dyy;
  logic signed [17:0] pxp_q, pyp_q;
  logic [DIST_W-1:0] dxx_q, dyy_q;
  always_comb begin
    px_d = 18'(nx_i) * 18'(lamp_i.vx);
    py_d = 18'(ny_i) * 18'(lamp_i.vy);
    dx = $signed({1'b0, px_i}) - $signed({1'b0, lamp_i.x});
    dy = $signed({1'b0, py_i}) - $signed({1'b0, lamp_i.y});
    dxx = (2*COORD_BITS+2)'(dx) * (2*COORD_BITS+2)'(dx);
    dyy = (2*COORD_BITS+2)'(dy) * (2*COORD_BITS+2)'(dy);
  end
  always_ff @(posedge clk_i) begin
    pxp_q <= px_d;
    pyp_q <= py_d;
    dxx_q <= dxx[DIST_W-1:0];
    dyy_q <= dyy[DIST_W-1:0];
    r_q[0] <= r_i;
    g_q[0] <= g_i;
    b_q[0] <= b_i;
  end

  // stage 1: emboss term and distance sum
  logic signed [18:0] dot;
  logic signed [12:0] sh;
  logic signed [13:0] dv;
  logic [7:0] demb;
  logic dpos;
  logic [DIST_W-1:0] dist_q;
  logic [RAD_W-1:0] rad;
  always_comb begin
    dot = 19'(pxp_q) + 19'(pyp_q);
    sh = 13'(dot >>> 7);
    dv = 14'(sh) + 14'(EMBOSS_BIAS);
    dpos = dv > 14'sd0;
    demb = (dv > 14'sd255) ? 8'd255 : dv[7:0];
    rad = (lamp_i.rad == '0) ? RAD_W'(1) : lamp_i.rad;
  end
  always_ff @(posedge clk_i) begin
    dist_q <= DIST_W'(dxx_q + dyy_q);
    d_q[1] <= demb;
    r_q[1] <= r_q[0];
    g_q[1] <= g_q[0];
    b_q[1] <= b_q[0];
  end
  logic dpos_q;
  always_ff @(posedge clk_i) dpos_q <= dpos;

  // divider chain: one cell per quotient bit, MSB first
  logic [DIST_W-1:0] num_c [NDIV+1];
  logic [QUO_W-1:0] quo_c [NDIV+1];
  logic [NDIV:0] dv_c;
  logic [RAD_W-1:0] rad_c [NDIV+1];
  logic [NDIV:0] on_c;
  assign num_c[0] = dist_q;
  assign quo_c[0] = '0;
  assign dv_c[0] = vld_q[1];
  assign rad_c[0] = rad;
  assign on_c[0] = dpos_q;

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    nmpls_div u_div (
      .clk_i, .rst_ni,
      .vld_i(dv_c[i]), .num_i(num_c[i]), .quo_i(quo_c[i]), .den_i(rad_c[i]),
      .vld_chk_i(1'b1), .vld_o(dv_c[i+1]), .num_o(num_c[i+1]), .quo_o(quo_c[i+1]),
      .bit_i(5'(NDIV-1-i))
    );
    always_ff @(posedge clk_i) begin
      rad_c[i+1] <= rad_c[i];
      on_c[i+1] <= on_c[i];
      d_q[i+2] <= d_q[i+1];
      r_q[i+2] <= r_q[i+1];
      g_q[i+2] <= g_q[i+1];
      b_q[i+2] <= b_q[i+1];
    end
  end

  // rom read
  logic [7:0] rom_q;
  logic hit_q;
  always_ff @(posedge clk_i) begin
    rom_q <= rom_w[quo_c[NDIV][ROM_AW-1:0]];
    hit_q <= on_c[NDIV] && (quo_c[NDIV] <= QUO_W'(FALLOFF_ENTRIES - 1));
    d_q[SR] <= d_q[SR-1];
    r_q[SR] <= r_q[SR-1];
    g_q[SR] <= g_q[SR-1];
    b_q[SR] <= b_q[SR-1];
  end

  // amount
  logic [15:0] amt_p;
  logic [8:0] amt_q;
  assign amt_p = d_q[SR] * rom_q;
  always_ff @(posedge clk_i) begin
    amt_q <= hit_q ? 9'(amt_p >> 7) : 9'd0;
    r_q[SR+1] <= r_q[SR];
    g_q[SR+1] <= g_q[SR];
    b_q[SR+1] <= b_q[SR];
  end

  // color add, held at the top of the range
  logic [16:0] pr, pg, pb;
  logic [10:0] sr, sg, sb;
  always_comb begin
    pr = lamp_i.r * amt_q;
    pg = lamp_i.g * amt_q;
    pb = lamp_i.b * amt_q;
    sr = 11'(r_q[SR+1]) + 11'(pr >> 8);
    sg = 11'(g_q[SR+1]) + 11'(pg >> 8);
    sb = 11'(b_q[SR+1]) + 11'(pb >> 8);
  end
  always_ff @(posedge clk_i) begin
    r_o <= sr[10] ? 10'h3FF : sr[9:0];
    g_o <= sg[10] ? 10'h3FF : sg[9:0];
    b_o <= sb[10] ? 10'h3FF : sb[9:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-1:0], vld_i};
    end
  end
  assign vld_o = vld_q[NS];
  logic unused;
  assign unused = ^{vld_q[NS-1:2], dv_c[NDIV], num_c[NDIV]};
endmodule

>>> src/normal_map_point_light_shader_top.sv
`timescale 1ns / 1ps
// Normal-mapped point-light pixel shader.
// Input: start_i with pixel_x_i, pixel_y_i, normal_x_i, normal_y_i, occlusion_i.
//   An item is taken on every edge where start_i is high and busy_o is low;
//   busy_o is always low, so one pixel per cycle is taken.
// Output: done_o strobes for one cycle with red_o, green_o, blue_o.
//   Results come back in order; the receiver cannot stall them.
// Lamps: each is a chain of cells: products, emboss, one cell per quotient
//   bit of squared distance/radius, falloff ROM, amount, color add.
// Throughput: one item per cycle.
// Config: cfg_we_i, cfg_idx_i, cfg_data_i write a register in the same cycle;
//   write only while no items are in flight.
// Reset: clears the config registers to their defaults (radius 1, black, ambient 0)
//   and drops items in flight.
module normal_map_point_light_shader_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [11:0]                  pixel_x_i,
  input  logic [11:0]                  pixel_y_i,
  input  logic signed [7:0]            normal_x_i,
  input  logic signed [7:0]            normal_y_i,
  input  logic [7:0]                   occlusion_i,
  input  logic                         cfg_we_i,
  input  logic [nmpls_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [nmpls_pkg::CFG_W-1:0]  cfg_data_i,
  output logic                         done_o,
  output logic [7:0]                   red_o,
  output logic [7:0]                   green_o,
  output logic [7:0]                   blue_o
);
  import nmpls_pkg::*;
  localparam int LAT = LAMP_LAT;

  logic [41:0] place_q [3];
  logic [43:0] look_q [3];
  logic [23:0] amb_q;
  lamp_t lamp [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        place_q[k] <= '0;
        look_q[k] <= 44'd1;
      end
      amb_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_L0_PLACE: place_q[0] <= cfg_data_i[41:0];
        REG_L0_LOOK:  look_q[0] <= cfg_data_i;
        REG_L1_PLACE: place_q[1] <= cfg_data_i[41:0];
        REG_L1_LOOK:  look_q[1] <= cfg_data_i;
        REG_L2_PLACE: place_q[2] <= cfg_data_i[41:0];
        REG_L2_LOOK:  look_q[2] <= cfg_data_i;
        REG_AMBIENT:  amb_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lamp[k].x = place_q[k][COORD_BITS-1:0];
      lamp[k].y = place_q[k][2*COORD_BITS-1:COORD_BITS];
      lamp[k].vx = place_q[k][2*COORD_BITS+8:2*COORD_BITS];
      lamp[k].vy = place_q[k][2*COORD_BITS+17:2*COORD_BITS+9];
      lamp[k].rad = look_q[k][19:0];
      lamp[k].r = look_q[k][27:20];
      lamp[k].g = look_q[k][35:28];
      lamp[k].b = look_q[k][43:36];
    end
  end

  assign busy_o = 1'b0;

  // ambient stage
  logic vld_q;
  logic [COORD_BITS-1:0] px_q, py_q;
  logic signed [7:0] nx_q, ny_q;
  logic [9:0] ar_q, ag_q, ab_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else vld_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    px_q <= pixel_x_i;
    py_q <= pixel_y_i;
    nx_q <= normal_x_i;
    ny_q <= normal_y_i;
    ar_q <= 10'((16'(amb_q[23:16]) * 16'(occlusion_i)) >> 9);
    ag_q <= 10'((16'(amb_q[15:8]) * 16'(occlusion_i)) >> 9);
    ab_q <= 10'((16'(amb_q[7:0]) * 16'(occlusion_i)) >> 9);
  end

  // delay pixel data between lamp cells
  logic [LAMP_COUNT:0] v_c;
  logic [9:0] r_c [LAMP_COUNT+1];
  logic [9:0] g_c [LAMP_COUNT+1];
  logic [9:0] b_c [LAMP_COUNT+1];
  logic [2*COORD_BITS+15:0] pix_c [LAMP_COUNT+1];
  logic [2*COORD_BITS+15:0] pd_q [LAMP_COUNT][LAT];
  assign v_c[0] = vld_q;
  assign r_c[0] = ar_q;
  assign g_c[0] = ag_q;
  assign b_c[0] = ab_q;
  assign pix_c[0] = {px_q, py_q, nx_q, ny_q};

  for (genvar k = 0; k < LAMP_COUNT; k++) begin : g_lamp
    nmpls_lamp u_lamp (
      .clk_i, .rst_ni,
      .vld_i(v_c[k]), .lamp_i(lamp[k]),
      .px_i(pix_c[k][2*COORD_BITS+15:COORD_BITS+16]),
      .py_i(pix_c[k][COORD_BITS+15:16]),
      .nx_i(pix_c[k][15:8]), .ny_i(pix_c[k][7:0]),
      .r_i(r_c[k]), .g_i(g_c[k]), .b_i(b_c[k]),
      .vld_o(v_c[k+1]), .r_o(r_c[k+1]), .g_o(g_c[k+1]), .b_o(b_c[k+1])
    );
    always_ff @(posedge clk_i) begin
      pd_q[k][0] <= pix_c[k];
      for (int s = 1; s < LAT; s++) pd_q[k][s] <= pd_q[k][s-1];
    end
    assign pix_c[k+1] = pd_q[k][LAT-1];
  end

  logic done_q;
  logic [7:0] r_q, g_q, b_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else done_q <= v_c[LAMP_COUNT];
  end
  always_ff @(posedge clk_i) begin
    r_q <= (r_c[LAMP_COUNT] > 10'd255) ? 8'd255 : r_c[LAMP_COUNT][7:0];
    g_q <= (g_c[LAMP_COUNT] > 10'd255) ? 8'd255 : g_c[LAMP_COUNT][7:0];
    b_q <= (b_c[LAMP_COUNT] > 10'd255) ? 8'd255 : b_c[LAMP_COUNT][7:0];
  end
  assign done_o = done_q;
  assign red_o = r_q;
  assign green_o = g_q;
  assign blue_o = b_q;
  logic unused;
  assign unused = ^pix_c[LAMP_COUNT];
endmodule

>>> src/nmpls_chk.sv
`timescale 1ns / 1ps
module nmpls_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);
  import nmpls_pkg::*;
  localparam int LAT = LAMP_COUNT * LAMP_LAT + 2;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LAT done_o) else $error("result missing");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT)) else $error("result invented");
endmodule

bind normal_map_point_light_shader_top nmpls_chk u_chk (.*);

>>> tb/sv/tb_normal_map_point_light_shader_top.sv
`timescale 1ns / 1ps
module tb_normal_map_point_light_shader_top;
  import nmpls_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int TAIL_CYCLES = 120;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [11:0]           pixel_x_i;
  logic [11:0]           pixel_y_i;
  logic signed [7:0]     normal_x_i;
  logic signed [7:0]     normal_y_i;
  logic [7:0]            occlusion_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_data_i;
  logic                  done_o;
  logic [7:0]            red_o;
  logic [7:0]            green_o;
  logic [7:0]            blue_o;

  normal_map_point_light_shader_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .normal_x_i  (normal_x_i),
    .normal_y_i  (normal_y_i),
    .occlusion_i (occlusion_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  reg_idx_e place_reg [3] = '{REG_L0_PLACE, REG_L1_PLACE, REG_L2_PLACE};
  reg_idx_e look_reg [3] = '{REG_L0_LOOK, REG_L1_LOOK, REG_L2_LOOK};

  logic [CFG_W-1:0] shadow_regs [8];
  logic [7:0]       falloff_tab [FALLOFF_ENTRIES];
  color_t           color_q [$];
  int               err_cnt;
  int               cycle_cnt;
  bit               gaps_on;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic color_t shade_pixel(logic [11:0] px, logic [11:0] py,
                                         logic signed [7:0] nx, logic signed [7:0] ny,
                                         logic [7:0] ao);
    logic [CFG_W-1:0] place;
    logic [CFG_W-1:0] look;
    logic [CFG_W-1:0] amb;
    logic [RAD_W-1:0] rad;
    int acc_r, acc_g, acc_b;
    int dot, d, dx, dy, dist_sq, q, amt;
    color_t c;
    begin
      amb = shadow_regs[REG_AMBIENT];
      acc_r = (int'(amb[23:16]) * int'(ao)) >> 9;
      acc_g = (int'(amb[15:8]) * int'(ao)) >> 9;
      acc_b = (int'(amb[7:0]) * int'(ao)) >> 9;
      for (int k = 0; k < LAMP_COUNT; k++) begin
        place = shadow_regs[place_reg[k]];
        look = shadow_regs[look_reg[k]];
        dot = int'(nx) * int'($signed(place[32:24])) + int'(ny) * int'($signed(place[41:33]));
        d = EMBOSS_BIAS + (dot >>> 7);
        if (d <= 0) continue;
        if (d > 255) d = 255;
        dx = int'(px) - int'(place[11:0]);
        dy = int'(py) - int'(place[23:12]);
        dist_sq = dx * dx + dy * dy;
        rad = look[19:0];
        if (rad == 0) rad = 1;
        q = dist_sq / int'(rad);
        if (q > FALLOFF_ENTRIES - 1) continue;
        amt = (d * int'(falloff_tab[q])) >> 7;
        acc_r += (int'(look[27:20]) * amt) >> 8;
        acc_g += (int'(look[35:28]) * amt) >> 8;
        acc_b += (int'(look[43:36]) * amt) >> 8;
      end
      c.red = acc_r > 255 ? 8'hFF : acc_r[7:0];
      c.green = acc_g > 255 ? 8'hFF : acc_g[7:0];
      c.blue = acc_b > 255 ? 8'hFF : acc_b[7:0];
      return c;
    end
  endfunction

  always @(posedge clk_i) begin
    color_t got;
    color_t want;
    if (rst_ni && done_o) begin
      got = '{red_o, green_o, blue_o};
      if (color_q.size() == 0) begin
        $display("%0t unexpected result r=%0d g=%0d b=%0d", $time, red_o, green_o, blue_o);
        err_cnt++;
      end else begin
        want = color_q.pop_front();
        if (got.red !== want.red) begin
          $display("%0t red expected %0d actual %0d", $time, want.red, got.red);
          err_cnt++;
        end
        if (got.green !== want.green) begin
          $display("%0t green expected %0d actual %0d", $time, want.green, got.green);
          err_cnt++;
        end
        if (got.blue !== want.blue) begin
          $display("%0t blue expected %0d actual %0d", $time, want.blue, got.blue);
          err_cnt++;
        end
      end
    end
  end

  task automatic send_pixel(logic [11:0] px, logic [11:0] py, logic [7:0] nx,
                            logic [7:0] ny, logic [7:0] ao);
    while (gaps_on && $urandom_range(99) < 23) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    pixel_x_i = px;
    pixel_y_i = py;
    normal_x_i = nx;
    normal_y_i = ny;
    occlusion_i = ao;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    color_q.push_back(shade_pixel(px, py, nx, ny, ao));
    @(negedge clk_i);
  endtask

  // hold until every pending item is back
  task automatic drain;
    start_i = 1'b0;
    while (color_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    case (idx)
      REG_L0_PLACE, REG_L1_PLACE, REG_L2_PLACE: shadow_regs[idx] = {2'b0, data[41:0]};
      REG_L0_LOOK, REG_L1_LOOK, REG_L2_LOOK:    shadow_regs[idx] = data;
      REG_AMBIENT:                              shadow_regs[idx] = {20'b0, data[23:0]};
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pack_place(logic [11:0] x, logic [11:0] y,
                                                  logic [8:0] vx, logic [8:0] vy);
    return {2'b0, vy, vx, y, x};
  endfunction

  function automatic logic [CFG_W-1:0] pack_look(logic [19:0] rad, logic [7:0] r,
                                                 logic [7:0] g, logic [7:0] b);
    return {b, g, r, rad};
  endfunction

  task automatic test_reset_defaults;
    send_pixel(12'd0, 12'd0, 8'sd127, 8'sd127, 8'hFF);
    send_pixel(12'hFFF, 12'hFFF, -8'sd128, -8'sd128, 8'h00);
    send_pixel(12'd1, 12'd0, 8'sd0, 8'sd0, 8'd128);
    drain();
  endtask

  task automatic test_directed;
    write_reg(REG_L0_PLACE, pack_place(12'd0, 12'd0, 9'h0FF, 9'h0FF));
    write_reg(REG_L0_LOOK, pack_look(20'd0, 8'hFF, 8'hFF, 8'hFF));
    write_reg(REG_L1_PLACE, pack_place(12'hFFF, 12'hFFF, 9'h100, 9'h100));
    write_reg(REG_L1_LOOK, pack_look(20'hFFFFF, 8'hFF, 8'h00, 8'h80));
    write_reg(REG_L2_PLACE, pack_place(12'd2048, 12'd100, 9'h100, 9'h0FF));
    write_reg(REG_L2_LOOK, pack_look(20'd16, 8'h40, 8'hC0, 8'h01));
    write_reg(REG_AMBIENT, 44'hFF_FFFF);
    write_reg(REG_UNUSED, {CFG_W{1'b1}});
    send_pixel(12'd0, 12'd0, 8'sd127, 8'sd127, 8'hFF);
    send_pixel(12'd0, 12'd0, -8'sd128, -8'sd128, 8'h00);
    send_pixel(12'd0, 12'd0, 8'sd0, 8'sd0, 8'hFF);
    send_pixel(12'd31, 12'd0, 8'sd100, 8'sd0, 8'h00);
    send_pixel(12'd32, 12'd0, 8'sd100, 8'sd0, 8'h00);
    send_pixel(12'hFFF, 12'hFFF, -8'sd128, -8'sd128, 8'h01);
    send_pixel(12'hFFF, 12'hFFF, 8'sd127, 8'sd127, 8'hFF);
    send_pixel(12'd2048, 12'd100, -8'sd128, 8'sd127, 8'h80);
    send_pixel(12'd2060, 12'd110, 8'sd127, -8'sd128, 8'h7F);
    send_pixel(12'd2176, 12'd100, -8'sd37, 8'sd1, 8'h00);
    send_pixel(12'd0, 12'hFFF, 8'sd1, -8'sd1, 8'hFF);
    send_pixel(12'hFFF, 12'd0, -8'sd1, 8'sd1, 8'hFF);
    drain();
    write_reg(REG_AMBIENT, 44'h0);
    write_reg(REG_L0_LOOK, pack_look(20'd1, 8'hFF, 8'h01, 8'h7F));
    send_pixel(12'd0, 12'd0, -8'sd74, 8'sd0, 8'hFF);
    send_pixel(12'd0, 12'd0, -8'sd75, 8'sd0, 8'hFF);
    send_pixel(12'd22, 12'd22, 8'sd60, 8'sd60, 8'hFF);
    send_pixel(12'd23, 12'd0, 8'sd60, 8'sd60, 8'hFF);
    drain();
  endtask

  task automatic randomize_lamps;
    logic [19:0] rad;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(3))
        0: rad = 20'd0;
        1: rad = 20'($urandom_range(1, 64));
        2: rad = 20'($urandom);
        default: rad = 20'($urandom_range(2000, 40000));
      endcase
      write_reg(place_reg[k], pack_place(12'($urandom), 12'($urandom), 9'($urandom),
                                         9'($urandom)));
      write_reg(look_reg[k], pack_look(rad, 8'($urandom), 8'($urandom), 8'($urandom)));
    end
    write_reg(REG_AMBIENT, 44'($urandom));
  endtask

  task automatic send_random_pixel;
    logic [CFG_W-1:0] place;
    logic [11:0] px, py;
    begin
      if ($urandom_range(1)) begin
        place = shadow_regs[place_reg[$urandom_range(2)]];
        px = place[11:0] + 12'($urandom_range(0, 255)) - 12'd128;
        py = place[23:12] + 12'($urandom_range(0, 255)) - 12'd128;
      end else begin
        px = 12'($urandom);
        py = 12'($urandom);
      end
      send_pixel(px, py, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random_scenes;
    for (int phase = 0; phase < 11; phase++) begin
      randomize_lamps();
      gaps_on = (phase != 4);
      for (int n = 0; n < 50; n++) begin
        send_random_pixel();
        if (phase == 7 && n == 25) drain();
      end
      drain();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    pixel_x_i = '0;
    pixel_y_i = '0;
    normal_x_i = '0;
    normal_y_i = '0;
    occlusion_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    err_cnt = 0;
    cycle_cnt = 0;
    gaps_on = 1'b1;
    for (int i = 0; i < FALLOFF_ENTRIES; i++) begin
      longint unsigned e;
      longint unsigned v;
      e = FALLOFF_ENTRIES - i;
      v = (255 * e * e) / (FALLOFF_ENTRIES * (FALLOFF_ENTRIES + 7 * i));
      falloff_tab[i] = v[7:0];
    end
    shadow_regs[REG_L0_PLACE] = '0;
    shadow_regs[REG_L0_LOOK] = 44'd1;
    shadow_regs[REG_L1_PLACE] = '0;
    shadow_regs[REG_L1_LOOK] = 44'd1;
    shadow_regs[REG_L2_PLACE] = '0;
    shadow_regs[REG_L2_LOOK] = 44'd1;
    shadow_regs[REG_AMBIENT] = '0;
    shadow_regs[REG_UNUSED] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_directed();
    test_random_scenes();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && color_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/nmpls_pkg.sv
src/nmpls_div.sv
src/nmpls_lamp.sv
src/normal_map_point_light_shader_top.sv
src/nmpls_chk.sv
tb/sv/tb_normal_map_point_light_shader_top.sv
